// ===== hw/rtl/sgd_pkg.sv =====
// Shared constants, register codes and types of the shake gesture detector.
`default_nettype none

package sgd_pkg;

	localparam int unsigned SAMPLE_WIDTH_DEF = 16;
	localparam int unsigned COUNT_WIDTH_DEF  = 8;

	// configuration port
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned THR_W     = 32;
	localparam int unsigned LIMIT_W   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUIET_THR   = 3'd0,
		REG_ACTIVE_THR  = 3'd1,
		REG_MIN_QUIET   = 3'd2,
		REG_MIN_ACTIVE  = 3'd3,
		REG_MIN_REV     = 3'd4,
		REG_QUIET_TMO   = 3'd5
	} cfg_reg_t;

	// reset values: 1.2 g^2 and 2.0 g^2 in Q8.24
	localparam logic [THR_W-1:0]   QUIET_THR_RST  = 32'd20132659;
	localparam logic [THR_W-1:0]   ACTIVE_THR_RST = 32'd33554432;
	localparam logic [LIMIT_W-1:0] MIN_QUIET_RST  = 8'd5;
	localparam logic [LIMIT_W-1:0] MIN_ACTIVE_RST = 8'd5;
	localparam logic [LIMIT_W-1:0] MIN_REV_RST    = 8'd2;
	localparam logic [LIMIT_W-1:0] QUIET_TMO_RST  = 8'd8;

	typedef struct packed {
		logic quiet;
		logic active;
	} sgd_class_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] min_quiet;
		logic [LIMIT_W-1:0] min_active;
		logic [LIMIT_W-1:0] min_rev;
		logic [LIMIT_W-1:0] quiet_tmo;
	} sgd_limits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgd_sample_if.sv =====
// Sample channel: valid/ready handshake with a three-axis acceleration payload.
`default_nettype none

interface sgd_sample_if #(
	parameter int unsigned SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sgd_result_if.sv =====
// Result channel: valid/ready handshake with the shake flag.
`default_nettype none

interface sgd_result_if;
	logic valid;
	logic ready;
	logic shake_detected;

	modport source (output valid, output shake_detected, input ready);
	modport sink (input valid, input shake_detected, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sgd_classify.sv =====
// Squared magnitude of one sample and its quiet/active classification.
`default_nettype none

module sgd_classify #(
	parameter int unsigned SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic signed [SAMPLE_WIDTH-1:0] x,
	input  wire logic signed [SAMPLE_WIDTH-1:0] y,
	input  wire logic signed [SAMPLE_WIDTH-1:0] z,
	input  wire logic [sgd_pkg::THR_W-1:0]      quiet_thr,
	input  wire logic [sgd_pkg::THR_W-1:0]      active_thr,
	output sgd_pkg::sgd_class_t                 cls
);
	import sgd_pkg::*;

	// three squares of SAMPLE_WIDTH bits stay below 2^(2*SAMPLE_WIDTH)
	localparam int unsigned SQ_W  = 2 * SAMPLE_WIDTH;
	localparam int unsigned CMP_W = (SQ_W > THR_W) ? SQ_W : THR_W;

	logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
	logic [SQ_W-1:0]        mag;
	logic [CMP_W-1:0]       mag_c;

	assign sq_x  = SQ_W'(x) * SQ_W'(x);
	assign sq_y  = SQ_W'(y) * SQ_W'(y);
	assign sq_z  = SQ_W'(z) * SQ_W'(z);
	assign mag   = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
	assign mag_c = CMP_W'(mag);

	// quiet wins when the thresholds overlap
	assign cls.quiet  = mag_c < CMP_W'(quiet_thr);
	assign cls.active = !cls.quiet && (mag_c > CMP_W'(active_thr));

endmodule

`default_nettype wire

// ===== hw/rtl/sgd_tracker.sv =====
// Gesture state: last active sample, activity/quiet/reversal counters, shake decision.
`default_nettype none

module sgd_tracker #(
	parameter int unsigned SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH  = sgd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           update,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x,
	input  wire logic signed [SAMPLE_WIDTH-1:0] y,
	input  wire logic signed [SAMPLE_WIDTH-1:0] z,
	input  sgd_pkg::sgd_class_t                 cls,
	input  sgd_pkg::sgd_limits_t                limits,
	output logic                                shake
);
	import sgd_pkg::*;

	localparam int unsigned DIF_W = SAMPLE_WIDTH + 1;
	localparam int unsigned PRD_W = 2 * SAMPLE_WIDTH + 1;
	localparam int unsigned DOT_W = PRD_W + 2;
	localparam int unsigned CC_W  = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic signed [SAMPLE_WIDTH-1:0] last_x_q, last_y_q, last_z_q;
	logic signed [SAMPLE_WIDTH-1:0] last_x_d, last_y_d, last_z_d;
	logic [COUNT_WIDTH-1:0]         act_cnt_q, quiet_cnt_q, rev_cnt_q;
	logic [COUNT_WIDTH-1:0]         act_cnt_d, quiet_cnt_d, rev_cnt_d;
	logic [COUNT_WIDTH-1:0]         quiet_base;

	logic signed [DIF_W-1:0] dx, dy, dz;
	logic signed [PRD_W-1:0] px, py, pz;
	logic signed [DOT_W-1:0] dot;
	logic                    reversal;
	logic                    shake_ok;

	// direction reversal: last . (sample - last) < 0
	assign dx  = DIF_W'(x) - DIF_W'(last_x_q);
	assign dy  = DIF_W'(y) - DIF_W'(last_y_q);
	assign dz  = DIF_W'(z) - DIF_W'(last_z_q);
	assign px  = PRD_W'(last_x_q) * PRD_W'(dx);
	assign py  = PRD_W'(last_y_q) * PRD_W'(dy);
	assign pz  = PRD_W'(last_z_q) * PRD_W'(dz);
	assign dot = DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
	assign reversal = dot[DOT_W-1];

	assign shake_ok = (CC_W'(quiet_cnt_q) > CC_W'(limits.min_quiet))
	               && (CC_W'(act_cnt_q) > CC_W'(limits.min_active))
	               && (CC_W'(rev_cnt_q) > CC_W'(limits.min_rev));

	assign shake = cls.quiet && shake_ok;

	always_comb begin
		last_x_d    = last_x_q;
		last_y_d    = last_y_q;
		last_z_d    = last_z_q;
		act_cnt_d   = act_cnt_q;
		quiet_cnt_d = quiet_cnt_q;
		rev_cnt_d   = rev_cnt_q;
		quiet_base  = quiet_cnt_q;
		if (cls.quiet) begin
			if (shake_ok) begin
				act_cnt_d  = '0;
				rev_cnt_d  = '0;
				quiet_base = '0;
				last_x_d   = '0;
				last_y_d   = '0;
				last_z_d   = '0;
			end
			// long quiet run drops the gesture in progress
			if (CC_W'(quiet_base) > CC_W'(limits.quiet_tmo)) begin
				act_cnt_d = '0;
				rev_cnt_d = '0;
				last_x_d  = '0;
				last_y_d  = '0;
				last_z_d  = '0;
			end
			quiet_cnt_d = (quiet_base == CNT_MAX) ? CNT_MAX : quiet_base + CNT_ONE;
		end else if (cls.active) begin
			if (reversal && rev_cnt_q != CNT_MAX) begin
				rev_cnt_d = rev_cnt_q + CNT_ONE;
			end
			last_x_d    = x;
			last_y_d    = y;
			last_z_d    = z;
			act_cnt_d   = (act_cnt_q == CNT_MAX) ? CNT_MAX : act_cnt_q + CNT_ONE;
			quiet_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			act_cnt_q   <= '0;
			quiet_cnt_q <= '0;
			rev_cnt_q   <= '0;
		end else if (update) begin
			last_x_q    <= last_x_d;
			last_y_q    <= last_y_d;
			last_z_q    <= last_z_d;
			act_cnt_q   <= act_cnt_d;
			quiet_cnt_q <= quiet_cnt_d;
			rev_cnt_q   <= rev_cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/shake_gesture_detector.sv =====
// Shake gesture detector top level: config registers, input register, result register.
// Path: sample transaction -> input register -> result register -> result.valid.
// Throughput: one sample transaction per cycle unless the result stalls.
// A stalled result lets the input register take one more transaction, then sample.ready drops.
// Reset (arst_n low, async): empty, counters and last sample zero, thresholds 1.2 / 2.0 g^2,
// limits 5, 5, 2, 8.
`default_nettype none

module shake_gesture_detector #(
	parameter int unsigned SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH  = sgd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sgd_sample_if.sink                         sample,
	sgd_result_if.source                       result,
	input  wire logic                          cfg_we,
	input  wire logic [sgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sgd_pkg::CFG_W-1:0]     cfg_data
);
	import sgd_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers; out-of-range indexes are dropped.
	// ---------------------------------------------------------------
	logic [THR_W-1:0] quiet_thr_q;
	logic [THR_W-1:0] active_thr_q;
	sgd_limits_t      limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_thr_q         <= QUIET_THR_RST;
			active_thr_q        <= ACTIVE_THR_RST;
			limits_q.min_quiet  <= MIN_QUIET_RST;
			limits_q.min_active <= MIN_ACTIVE_RST;
			limits_q.min_rev    <= MIN_REV_RST;
			limits_q.quiet_tmo  <= QUIET_TMO_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_QUIET_THR:  quiet_thr_q         <= cfg_data[THR_W-1:0];
				REG_ACTIVE_THR: active_thr_q        <= cfg_data[THR_W-1:0];
				REG_MIN_QUIET:  limits_q.min_quiet  <= cfg_data[LIMIT_W-1:0];
				REG_MIN_ACTIVE: limits_q.min_active <= cfg_data[LIMIT_W-1:0];
				REG_MIN_REV:    limits_q.min_rev    <= cfg_data[LIMIT_W-1:0];
				REG_QUIET_TMO:  limits_q.quiet_tmo  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control.
	//   out_free: result register can take a new transaction
	//   s1 loads whenever it is empty or its contents move on
	// ---------------------------------------------------------------
	logic s1_vld_q, out_vld_q;
	logic out_free, s1_ld;
	logic s1_fire;

	assign out_free = !out_vld_q || result.ready;
	assign s1_ld    = !s1_vld_q || out_free;
	assign s1_fire  = s1_vld_q && out_free;

	assign sample.ready = s1_ld;
	assign result.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_ld) begin
				s1_vld_q <= sample.valid;
			end
			if (out_free) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	// ---------------------------------------------------------------
	// Input register. Squared magnitude and class are formed from it.
	// ---------------------------------------------------------------
	logic signed [SAMPLE_WIDTH-1:0] x_s1, y_s1, z_s1;
	sgd_class_t                     cls_s1;

	always_ff @(posedge clk) begin
		if (s1_ld && sample.valid) begin
			x_s1 <= sample.accel_x;
			y_s1 <= sample.accel_y;
			z_s1 <= sample.accel_z;
		end
	end

	sgd_classify #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_classify (
		.x          (x_s1),
		.y          (y_s1),
		.z          (z_s1),
		.quiet_thr  (quiet_thr_q),
		.active_thr (active_thr_q),
		.cls        (cls_s1)
	);

	// ---------------------------------------------------------------
	// Gesture state. The tracker updates its state when this
	// transaction moves into the result register, so the next sample
	// sees it in the following cycle.
	// ---------------------------------------------------------------
	logic shake;

	sgd_tracker #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.update (s1_fire),
		.x      (x_s1),
		.y      (y_s1),
		.z      (z_s1),
		.cls    (cls_s1),
		.limits (limits_q),
		.shake  (shake)
	);

	// ---------------------------------------------------------------
	// Result register.
	// ---------------------------------------------------------------
	logic shake_q;

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			shake_q <= shake;
		end
	end

	assign result.shake_detected = shake_q;

endmodule

`default_nettype wire
